FILE: design/brf_pkg.sv
package brf_pkg;

	// Sizes of the byte ring and of its lane-organized store.
	localparam int MEM_BYTES       = 256;
	localparam int MAX_BLOCK_BYTES = 8;
	localparam int PTR_W           = 8;
	localparam int LANES           = 8;
	localparam int LANE_W          = 3;
	localparam int ROWS            = MEM_BYTES / LANES;
	localparam int ROW_W           = PTR_W - LANE_W;
	localparam int BLK_W           = 4;
	localparam int DATA_W          = 64;
	localparam int CFG_W           = 8;

	// Request codes carried in the input tuser.
	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_BLOCK_BYTES     = 1'b0,
		REG_REQUESTED_BYTES = 1'b1
	} cfg_reg_t;

	// One block access handed from the control logic to the store.
	typedef struct packed {
		logic             we;
		logic             re;
		logic [PTR_W-1:0] ptr;
		logic [PTR_W-1:0] mask;
		logic [BLK_W-1:0] blk;
	} store_req_t;

	// Block size clamped to the range 1 to MAX_BLOCK_BYTES.
	function automatic logic [BLK_W-1:0] eff_block(input logic [BLK_W-1:0] b);
		logic [BLK_W-1:0] r;
		r = b;
		if (b == '0) begin
			r = BLK_W'(1);
		end else if (b > BLK_W'(MAX_BLOCK_BYTES)) begin
			r = BLK_W'(MAX_BLOCK_BYTES);
		end
		return r;
	endfunction

	// Smallest all-ones value that covers the requested capacity; zero maps to one.
	function automatic logic [PTR_W-1:0] ring_mask(input logic [PTR_W-1:0] r);
		logic [PTR_W-1:0] m;
		m = r;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		if (m == '0) begin
			m = PTR_W'(1);
		end
		return m;
	endfunction

	// Full rule: at a limit, or less than one block of room below either limit.
	function automatic logic full_rule(input logic [PTR_W-1:0] fill,
		input logic [PTR_W-1:0] mask, input logic [PTR_W-1:0] lim,
		input logic [BLK_W-1:0] blk);
		logic signed [PTR_W+1:0] room_m;
		logic signed [PTR_W+1:0] room_l;
		logic signed [PTR_W+1:0] b;
		room_m = $signed({2'b00, mask}) - $signed({2'b00, fill});
		room_l = $signed({2'b00, lim}) - $signed({2'b00, fill});
		b      = $signed({{(PTR_W+2-BLK_W){1'b0}}, blk});
		return (fill == mask) || (fill == lim) || (room_m < b) || (room_l < b);
	endfunction

	// Fill divided by the block size, using reciprocal multiplies for sizes that are not powers of two.
	function automatic logic [PTR_W-1:0] div_blk(input logic [PTR_W-1:0] n,
		input logic [BLK_W-1:0] b);
		logic [17:0] p;
		logic [PTR_W-1:0] q;
		p = '0;
		q = n;
		case (b)
			4'd1: q = n;
			4'd2: q = n >> 1;
			4'd3: begin
				p = 18'(n) * 18'd171;
				q = PTR_W'(p >> 9);
			end
			4'd4: q = n >> 2;
			4'd5: begin
				p = 18'(n) * 18'd205;
				q = PTR_W'(p >> 10);
			end
			4'd6: begin
				p = 18'(n) * 18'd171;
				q = PTR_W'(p >> 10);
			end
			4'd7: begin
				p = 18'(n) * 18'd293;
				q = PTR_W'(p >> 11);
			end
			4'd8: q = n >> 3;
			default: q = n;
		endcase
		return q;
	endfunction

endpackage

FILE: design/brf_lane_ram.sv
module brf_lane_ram #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/brf_store.sv
module brf_store
	import brf_pkg::*;
(
	input  logic              clk,
	input  store_req_t        req,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [PTR_W-1:0]  addr     [MAX_BLOCK_BYTES];
	logic              lane_we  [LANES];
	logic              lane_re  [LANES];
	logic [ROW_W-1:0]  lane_row [LANES];
	logic [7:0]        lane_wd  [LANES];
	logic [7:0]        lane_rd  [LANES];
	logic [LANE_W-1:0] sel_s1   [MAX_BLOCK_BYTES];
	logic [BLK_W-1:0]  blk_s1;

	// Ring address of each byte of the block, wrapped by the mask.
	always_comb begin
		for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
			addr[i] = (req.ptr + PTR_W'(i)) & req.mask;
		end
	end

	// Route each byte of the block to the lane that holds its address.
	// Bytes of one block never share a lane unless they share an address.
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			lane_we[l]  = 1'b0;
			lane_re[l]  = 1'b0;
			lane_row[l] = '0;
			lane_wd[l]  = '0;
			for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
				if (addr[i][LANE_W-1:0] == LANE_W'(l) && BLK_W'(i) < req.blk) begin
					lane_we[l]  = req.we;
					lane_re[l]  = req.re;
					lane_row[l] = addr[i][PTR_W-1:LANE_W];
					lane_wd[l]  = wdata[8*i +: 8];
				end
			end
		end
	end

	// One byte-wide memory per lane.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		brf_lane_ram #(
			.DEPTH(ROWS),
			.WIDTH(8)
		) u_ram (
			.clk  (clk),
			.we   (lane_we[l]),
			.re   (lane_re[l]),
			.addr (lane_row[l]),
			.wdata(lane_wd[l]),
			.rdata(lane_rd[l])
		);
	end

	// Remember which lane feeds each output byte until the read data returns.
	always_ff @(posedge clk) begin
		if (req.re) begin
			for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
				sel_s1[i] <= addr[i][LANE_W-1:0];
			end
			blk_s1 <= req.blk;
		end
	end

	// Put the lane outputs back in block order; bytes past the block are zero.
	always_comb begin
		for (int i = 0; i < MAX_BLOCK_BYTES; i++) begin
			rdata[8*i +: 8] = (BLK_W'(i) < blk_s1) ? lane_rd[sel_s1[i]] : 8'h00;
		end
	end

endmodule

FILE: design/block_ring_fifo_core.sv
// Block ring FIFO: a byte ring that moves blocks of 1 to 8 bytes per request
// (push, pop or clear, given in s_tuser) and returns one status transfer per
// request with the popped block, empty, full, block count and a refused flag.
// The result is held in stage one and then loaded into the output register, and
// is offered from there; a new request is taken every cycle as long as results
// are taken, since the pointers are updated at the request edge and the store is
// read or written in that same cycle. The store is eight byte-wide lane memories
// of 32 rows with registered reads, so any block touches each lane at most once.
// Stored bytes are undefined after reset; there is no clearing pass. Write the
// block size and capacity registers only while no request is in flight.
module block_ring_fifo_core
	import brf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// Requests.
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [DATA_W-1:0] s_tdata,   // [63:0] push_data
	input  logic [1:0]        s_tuser,   // [1:0] req_type
	// Results.
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [79:0]       m_tdata,   // [63:0] read_data, [64] is_empty, [65] is_full,
	                                     // [73:66] block_count, [74] refused, [79:75] zero
	// Configuration.
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	logic [BLK_W-1:0]  blk_cfg_q;
	logic [PTR_W-1:0]  req_cfg_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic              valid_s1;
	logic              refused_s1;
	logic              pop_ok_s1;
	logic              m_tvalid_q;
	logic [79:0]       m_tdata_q;

	logic [BLK_W-1:0]  blk;
	logic [PTR_W-1:0]  mask;
	logic [PTR_W-1:0]  fill;
	logic              full_now;
	logic              empty_now;
	logic              accept;
	logic              load_out;
	logic              push_ok;
	logic              pop_ok;
	logic              clear;
	logic              refused;
	store_req_t        sreq;
	logic [DATA_W-1:0] store_rdata;
	logic [DATA_W-1:0] read_data;
	logic [PTR_W-1:0]  block_count;

	// Effective configuration and present status.
	assign blk       = eff_block(blk_cfg_q);
	assign mask      = ring_mask(req_cfg_q);
	assign fill      = (wp_q - rp_q) & mask;
	assign full_now  = full_rule(fill, mask, req_cfg_q, blk);
	assign empty_now = (wp_q == rp_q);

	// Handshake: a request is taken when stage one is empty or its pending result can move on.
	assign load_out = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || load_out;
	assign accept   = s_tvalid && s_tready;

	// Decode the request against the present pointers.
	always_comb begin
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		clear   = 1'b0;
		refused = 1'b0;
		case (s_tuser)
			REQ_PUSH: begin
				push_ok = accept && !full_now;
				refused = accept && full_now;
			end
			REQ_POP: begin
				pop_ok  = accept && !empty_now;
				refused = accept && empty_now;
			end
			REQ_CLEAR: clear = accept;
			default: ;
		endcase
	end

	// Block access to the store.
	always_comb begin
		sreq.we   = push_ok;
		sreq.re   = pop_ok;
		sreq.ptr  = push_ok ? wp_q : rp_q;
		sreq.mask = mask;
		sreq.blk  = blk;
	end

	brf_store u_store (
		.clk  (clk),
		.req  (sreq),
		.wdata(s_tdata),
		.rdata(store_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_cfg_q <= BLK_W'(1);
			req_cfg_q <= 8'hFF;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLOCK_BYTES:     blk_cfg_q <= cfg_data[BLK_W-1:0];
				REG_REQUESTED_BYTES: req_cfg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pointers move at the request edge; a move masks the pointer again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (clear) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= (wp_q + PTR_W'(blk)) & mask;
			end
			if (pop_ok) begin
				rp_q <= (rp_q + PTR_W'(blk)) & mask;
			end
		end
	end

	// Stage one holds the request outcome while the store read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			refused_s1 <= 1'b0;
			pop_ok_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1   <= 1'b1;
			refused_s1 <= refused;
			pop_ok_s1  <= pop_ok;
		end else if (load_out) begin
			valid_s1 <= 1'b0;
		end
	end

	// Status after the step comes from the updated pointers.
	assign read_data   = pop_ok_s1 ? store_rdata : '0;
	assign block_count = div_blk(fill, blk);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= {5'b0, refused_s1, block_count, full_now, empty_now, read_data};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: design/brf_checker.sv
module brf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	// A stalled result stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A refused request never returns block data.
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[74] |-> m_tdata[63:0] == 64'h0)
		else $error("refused request returned data");

	// An empty ring holds no blocks.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> m_tdata[73:66] == 8'h00)
		else $error("empty ring reports blocks");

	// A refusal leaves the ring empty (pop) or full (push).
	a_refused_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[74] |-> m_tdata[64] || m_tdata[65])
		else $error("refusal with ring neither empty nor full");

endmodule

bind block_ring_fifo_core brf_checker u_brf_checker (.*);
